/* hw/rtl/uniform_grid_spatial_hash_top_defines.svh */
// Assertion macros shared by the grid top level
`ifndef UNIFORM_GRID_SPATIAL_HASH_TOP_DEFINES_SVH
`define UNIFORM_GRID_SPATIAL_HASH_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define UGSH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ugsh check failed");

// Next-cycle implication
`define UGSH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ugsh check failed");

`endif

/* hw/rtl/ugsh_pkg.sv */
package ugsh_pkg;

  localparam int MODE_W  = 2;
  localparam int EID_W   = 16;
  localparam int POS_W   = 15;
  localparam int LEN_W   = 14;
  localparam int CS_W    = 13;
  localparam int DIM_W   = 7;
  localparam int DIV_W   = 16;
  localparam int CFG_W   = 13;
  localparam int CFGI_W  = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [CFGI_W-1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_GRID_ROWS = 2'd2;

  localparam logic [CS_W-1:0]  CELL_SIZE_RST = 13'd32;
  localparam logic [DIM_W-1:0] GRID_DIM_RST  = 7'd64;

  typedef struct packed {
    logic load_item;
    logic sweep_step;
    logic div_start;
    logic div_latch;
    logic range_calc;
    logic cnt_rd;
    logic cnt_use;
    logic set_trunc;
    logic ent_rd;
    logic ent_take;
    logic cell_next;
    logic fin_load;
  } ugsh_cmd_t;

  typedef struct packed {
    logic              sweep_end;
    logic              div_done;
    logic              op_last;
    logic              any;
    logic [MODE_W-1:0] mode;
    logic              cnt_zero;
    logic              k_max;
    logic              k_next_max;
    logic              s_last;
    logic              x_end;
    logic              y_end;
    logic              pend;
    logic              out_free;
  } ugsh_sts_t;

endpackage

/* hw/rtl/ugsh_if.sv */
interface ugsh_in_if;
  import ugsh_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [EID_W-1:0]        entity_id;
  logic signed [POS_W-1:0] rect_x;
  logic signed [POS_W-1:0] rect_y;
  logic [LEN_W-1:0]        rect_w;
  logic [LEN_W-1:0]        rect_h;
  modport source (output valid, mode, entity_id, rect_x, rect_y, rect_w, rect_h,
                  input ready);
  modport sink (input valid, mode, entity_id, rect_x, rect_y, rect_w, rect_h,
                output ready);
endinterface

interface ugsh_out_if;
  import ugsh_pkg::*;
  logic             valid;
  logic             ready;
  logic [EID_W-1:0] found_id;
  logic             has_entity;
  logic             last;
  logic             overflow;
  modport source (output valid, found_id, has_entity, last, overflow, input ready);
  modport sink (input valid, found_id, has_entity, last, overflow, output ready);
endinterface

/* hw/rtl/ugsh_ram.sv */
module ugsh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/ugsh_div.sv */
module ugsh_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ugsh_pkg::DIV_W-1:0] num,
  input  logic [ugsh_pkg::CS_W-1:0]  den,
  output logic                      done,
  output logic [ugsh_pkg::DIV_W-1:0] quo,
  output logic                      neg
);
  import ugsh_pkg::*;
  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [CS_W-1:0]  rem_r, rem_nxt;
  logic             neg_r, neg_nxt;
  logic [CS_W:0]    trial;
  logic             qbit;

  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, den});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = num[DIV_W-1];
      dvd_nxt  = num[DIV_W-1] ? DIV_W'(-num) : num;
    end else if (busy_r) begin
      // one quotient bit a cycle, restoring
      rem_nxt = qbit ? CS_W'(trial - {1'b0, den}) : CS_W'(trial);
      dvd_nxt = {dvd_r[DIV_W-2:0], qbit};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = dvd_r;
  assign neg  = neg_r;
endmodule

/* hw/rtl/ugsh_datapath.sv */
module ugsh_datapath #(
  parameter int MAX_COLS      = 64,
  parameter int MAX_ROWS      = 64,
  parameter int CELL_CAPACITY = 16,
  parameter int MAX_RESULTS   = 64,
  parameter int ID_WIDTH      = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ugsh_pkg::ugsh_cmd_t               cmd,
  output ugsh_pkg::ugsh_sts_t               st,
  input  logic [ugsh_pkg::MODE_W-1:0]       in_mode,
  input  logic [ugsh_pkg::EID_W-1:0]        in_entity_id,
  input  logic signed [ugsh_pkg::POS_W-1:0] in_rect_x,
  input  logic signed [ugsh_pkg::POS_W-1:0] in_rect_y,
  input  logic [ugsh_pkg::LEN_W-1:0]        in_rect_w,
  input  logic [ugsh_pkg::LEN_W-1:0]        in_rect_h,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [ugsh_pkg::EID_W-1:0]        out_found_id,
  output logic                              out_has_entity,
  output logic                              out_last,
  output logic                              out_overflow,
  input  logic                              cfg_we,
  input  logic [ugsh_pkg::CFGI_W-1:0]       cfg_index,
  input  logic [ugsh_pkg::CFG_W-1:0]        cfg_wdata
);
  import ugsh_pkg::*;

  localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
  localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;
  localparam int CW   = NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1;
  localparam int SLW  = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int XW   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int YW   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int NCW  = $clog2(MAX_COLS + 1);
  localparam int NRW  = $clog2(MAX_ROWS + 1);
  localparam int CNTW = $clog2(CELL_CAPACITY + 1);
  localparam int KW   = $clog2(MAX_RESULTS + 1);

  // configuration
  logic [CS_W-1:0]  cell_size_r;
  logic [DIM_W-1:0] grid_cols_r, grid_rows_r;
  logic [CS_W-1:0]  cs_eff;
  logic [NCW-1:0]   cols_eff;
  logic [NRW-1:0]   rows_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CELL_SIZE_RST;
      grid_cols_r <= GRID_DIM_RST;
      grid_rows_r <= GRID_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE: cell_size_r <= cfg_wdata;
        CFG_GRID_COLS: grid_cols_r <= cfg_wdata[DIM_W-1:0];
        CFG_GRID_ROWS: grid_rows_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cs_eff = (cell_size_r == '0) ? CS_W'(1) : cell_size_r;
    if (grid_cols_r == '0) begin
      cols_eff = NCW'(1);
    end else if (32'(grid_cols_r) > MAX_COLS) begin
      cols_eff = NCW'(MAX_COLS);
    end else begin
      cols_eff = NCW'(grid_cols_r);
    end
    if (grid_rows_r == '0) begin
      rows_eff = NRW'(1);
    end else if (32'(grid_rows_r) > MAX_ROWS) begin
      rows_eff = NRW'(MAX_ROWS);
    end else begin
      rows_eff = NRW'(grid_rows_r);
    end
  end

  // request held for the whole operation
  logic [MODE_W-1:0]       mode_r;
  logic [ID_WIDTH-1:0]     id_r;
  logic signed [POS_W-1:0] rx_r, ry_r;
  logic [LEN_W-1:0]        rw_r, rh_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r <= in_mode;
      id_r   <= ID_WIDTH'(in_entity_id);
      rx_r   <= in_rect_x;
      ry_r   <= in_rect_y;
      rw_r   <= in_rect_w;
      rh_r   <= in_rect_h;
    end
  end

  // low and high edges of x, then of y, divided through one shared divider
  logic [1:0]       op_sel_r;
  logic [DIV_W-1:0] num;
  logic             div_done, div_neg;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] q_r [4];
  logic             qn_r [4];

  always_comb begin
    case (op_sel_r)
      2'd0:    num = DIV_W'(rx_r);
      2'd1:    num = DIV_W'(rx_r) + DIV_W'(rw_r);
      2'd2:    num = DIV_W'(ry_r);
      default: num = DIV_W'(ry_r) + DIV_W'(rh_r);
    endcase
  end

  ugsh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (cs_eff),
    .done  (div_done),
    .quo   (div_quo),
    .neg   (div_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_sel_r <= '0;
    end else if (cmd.load_item) begin
      op_sel_r <= '0;
    end else if (cmd.div_latch) begin
      op_sel_r <= op_sel_r + 2'd1;
    end
    if (cmd.div_latch) begin
      q_r[op_sel_r]  <= div_quo;
      qn_r[op_sel_r] <= div_neg;
    end
  end

  // clamp one axis; bit 32 is non-empty, then low and high cell
  function automatic logic [32:0] axis_rng(input logic [DIV_W-1:0] qa, input logic na,
                                           input logic [DIV_W-1:0] qb, input logic nb,
                                           input logic [DIV_W-1:0] n);
    logic [DIV_W-1:0] lo, hi, top;
    logic             ok;
    top = n - 16'd1;
    lo  = na ? '0 : qa;
    hi  = nb ? '0 : qb;
    if (hi > top) begin
      hi = top;
    end
    ok = !(nb && qb != '0) && (lo <= hi);
    return {ok, lo, hi};
  endfunction

  logic [32:0] xr, yr;
  assign xr = axis_rng(q_r[0], qn_r[0], q_r[1], qn_r[1], DIV_W'(cols_eff));
  assign yr = axis_rng(q_r[2], qn_r[2], q_r[3], qn_r[3], DIV_W'(rows_eff));

  // cell walk
  logic [XW-1:0]   x0_r, x1_r, x_r;
  logic [YW-1:0]   y1_r, y_r;
  logic [CW-1:0]   row_base_r, c_cur;
  logic [CNTW-1:0] n_r, s_r;
  logic [KW-1:0]   k_r;
  logic            pend_r, ovf_r, trunc_r;
  logic [ID_WIDTH-1:0] pend_id_r;
  logic [CW-1:0]   sweep_r;

  assign c_cur = CW'(x_r + row_base_r);

  logic [CNTW-1:0]     cnt_rdata;
  logic [ID_WIDTH-1:0] ent_rdata;
  logic                cnt_full;
  logic                cnt_we, ent_we;
  logic [CW-1:0]       cnt_waddr;
  logic [CNTW-1:0]     cnt_wdata;
  logic [SLW-1:0]      ent_waddr, ent_raddr;

  assign cnt_full  = (cnt_rdata >= CNTW'(CELL_CAPACITY));
  assign ent_we    = cmd.cnt_use && (mode_r == MODE_INSERT) && !cnt_full;
  assign cnt_we    = cmd.sweep_step || ent_we;
  assign cnt_waddr = cmd.sweep_step ? sweep_r : c_cur;
  assign cnt_wdata = cmd.sweep_step ? '0 : CNTW'(cnt_rdata + 1'b1);
  assign ent_waddr = SLW'(c_cur * CELL_CAPACITY) + SLW'(cnt_rdata);
  assign ent_raddr = SLW'(c_cur * CELL_CAPACITY) + SLW'(s_r);

  ugsh_ram #(.WIDTH(CNTW), .DEPTH(NUM_CELLS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.cnt_rd),
    .raddr (c_cur),
    .rdata (cnt_rdata)
  );

  ugsh_ram #(.WIDTH(ID_WIDTH), .DEPTH(NUM_SLOTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (id_r),
    .re    (cmd.ent_rd),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // output register
  logic             out_valid_r;
  logic [EID_W-1:0] found_r;
  logic             has_r, last_r, oflow_r;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      k_r         <= '0;
    end else begin
      if (cmd.sweep_step) begin
        sweep_r <= (sweep_r == CW'(NUM_CELLS - 1)) ? '0 : CW'(sweep_r + 1'b1);
      end
      if (cmd.fin_load || (cmd.ent_take && pend_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.range_calc) begin
        pend_r <= 1'b0;
        k_r    <= '0;
      end else if (cmd.ent_take) begin
        pend_r <= 1'b1;
        k_r    <= KW'(k_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.range_calc) begin
      x0_r       <= XW'(xr[31:16]);
      x1_r       <= XW'(xr[15:0]);
      y1_r       <= YW'(yr[15:0]);
      x_r        <= XW'(xr[31:16]);
      y_r        <= YW'(yr[31:16]);
      row_base_r <= CW'(yr[31:16] * cols_eff);
      ovf_r      <= 1'b0;
      trunc_r    <= 1'b0;
    end
    if (cmd.cell_next) begin
      if (x_r == x1_r) begin
        x_r        <= x0_r;
        y_r        <= YW'(y_r + 1'b1);
        row_base_r <= CW'(row_base_r + cols_eff);
      end else begin
        x_r <= XW'(x_r + 1'b1);
      end
    end
    if (cmd.cnt_use) begin
      n_r <= cnt_rdata;
      s_r <= '0;
      if (mode_r == MODE_INSERT && cnt_full) begin
        ovf_r <= 1'b1;
      end
    end
    if (cmd.set_trunc) begin
      trunc_r <= 1'b1;
    end
    if (cmd.ent_take) begin
      // release the held hit, keep the new one until its successor is known
      pend_id_r <= ent_rdata;
      s_r       <= CNTW'(s_r + 1'b1);
      if (pend_r) begin
        found_r <= EID_W'(pend_id_r);
        has_r   <= 1'b1;
        last_r  <= 1'b0;
        oflow_r <= 1'b0;
      end
    end
    if (cmd.fin_load) begin
      last_r <= 1'b1;
      case (mode_r)
        MODE_INSERT: begin
          found_r <= '0;
          has_r   <= 1'b0;
          oflow_r <= ovf_r;
        end
        MODE_QUERY: begin
          found_r <= pend_r ? EID_W'(pend_id_r) : '0;
          has_r   <= pend_r;
          oflow_r <= pend_r && trunc_r;
        end
        default: begin
          found_r <= '0;
          has_r   <= 1'b0;
          oflow_r <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    st.sweep_end  = (sweep_r == CW'(NUM_CELLS - 1));
    st.div_done   = div_done;
    st.op_last    = (op_sel_r == 2'd3);
    st.any        = xr[32] && yr[32];
    st.mode       = mode_r;
    st.cnt_zero   = (cnt_rdata == '0);
    st.k_max      = (k_r == KW'(MAX_RESULTS));
    st.k_next_max = (KW'(k_r + 1'b1) == KW'(MAX_RESULTS));
    st.s_last     = (CNTW'(s_r + 1'b1) == n_r);
    st.x_end      = (x_r == x1_r);
    st.y_end      = (y_r == y1_r);
    st.pend       = pend_r;
    st.out_free   = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_found_id   = found_r;
  assign out_has_entity = has_r;
  assign out_last       = last_r;
  assign out_overflow   = oflow_r;
endmodule

/* hw/rtl/ugsh_ctrl.sv */
module ugsh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ugsh_pkg::ugsh_sts_t st,
  output ugsh_pkg::ugsh_cmd_t cmd
);
  import ugsh_pkg::*;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISP     = 4'd2;
  localparam logic [3:0] S_DIV_GO   = 4'd3;
  localparam logic [3:0] S_DIV_WAIT = 4'd4;
  localparam logic [3:0] S_RANGE    = 4'd5;
  localparam logic [3:0] S_CRD      = 4'd6;
  localparam logic [3:0] S_CUSE     = 4'd7;
  localparam logic [3:0] S_ERD      = 4'd8;
  localparam logic [3:0] S_EGOT     = 4'd9;
  localparam logic [3:0] S_NEXT     = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       rsp_r, rsp_nxt;

  always_comb begin
    state_nxt = state_r;
    rsp_nxt   = rsp_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.sweep_step = 1'b1;
        if (st.sweep_end) begin
          state_nxt = rsp_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        case (st.mode)
          MODE_CLEAR: begin
            rsp_nxt   = 1'b1;
            state_nxt = S_CLR;
          end
          MODE_INSERT, MODE_QUERY: state_nxt = S_DIV_GO;
          default: state_nxt = S_FIN;
        endcase
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = st.op_last ? S_RANGE : S_DIV_GO;
        end
      end
      S_RANGE: begin
        cmd.range_calc = 1'b1;
        state_nxt      = st.any ? S_CRD : S_FIN;
      end
      S_CRD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CUSE;
      end
      S_CUSE: begin
        cmd.cnt_use = 1'b1;
        if (st.mode == MODE_INSERT || st.cnt_zero) begin
          state_nxt = S_NEXT;
        end else if (st.k_max) begin
          cmd.set_trunc = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = S_EGOT;
      end
      S_EGOT: begin
        // hold while the previous hit cannot leave
        if (!(st.pend && !st.out_free)) begin
          cmd.ent_take = 1'b1;
          if (st.s_last) begin
            state_nxt = S_NEXT;
          end else if (st.k_next_max) begin
            cmd.set_trunc = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      S_NEXT: begin
        if (st.x_end && st.y_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cell_next = 1'b1;
          state_nxt     = S_CRD;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin_load = 1'b1;
          rsp_nxt      = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      rsp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rsp_r   <= rsp_nxt;
    end
  end
endmodule

/* hw/rtl/uniform_grid_spatial_hash_top.sv */
// Broad-phase collision grid. A request carries a mode (insert, query, clear) and a
// rectangle; each one gives one result, except a query, which streams out every id
// stored in the covered cells, row by row, up to MAX_RESULTS. After reset, and for
// every clear, the cell counts are swept to zero one cell a cycle, and no request
// is taken during the sweep. An insert or query first divides each low and high
// edge of x and y through one shared 16-step divider, then walks the covered cells
// (count memory read, count use, advance for each cell); a query also reads each
// stored id from the entry memory, and waits while the result side holds off.
// Requests are handled one at a time. Configuration is to be written only while
// idle; the block itself does not enforce this.
module uniform_grid_spatial_hash_top #(
  parameter int MAX_COLS      = 64,
  parameter int MAX_ROWS      = 64,
  parameter int CELL_CAPACITY = 16,
  parameter int MAX_RESULTS   = 64,
  parameter int ID_WIDTH      = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ugsh_in_if.sink                     in_if,
  ugsh_out_if.source                  out_if,
  input  logic                        cfg_we,
  input  logic [ugsh_pkg::CFGI_W-1:0] cfg_index,
  input  logic [ugsh_pkg::CFG_W-1:0]  cfg_wdata
);
  import ugsh_pkg::*;
  `include "uniform_grid_spatial_hash_top_defines.svh"

  ugsh_cmd_t cmd;
  ugsh_sts_t st;
  logic      in_ready;

  ugsh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ugsh_datapath #(
    .MAX_COLS      (MAX_COLS),
    .MAX_ROWS      (MAX_ROWS),
    .CELL_CAPACITY (CELL_CAPACITY),
    .MAX_RESULTS   (MAX_RESULTS),
    .ID_WIDTH      (ID_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_mode        (in_if.mode),
    .in_entity_id   (in_if.entity_id),
    .in_rect_x      (in_if.rect_x),
    .in_rect_y      (in_if.rect_y),
    .in_rect_w      (in_if.rect_w),
    .in_rect_h      (in_if.rect_h),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_found_id   (out_if.found_id),
    .out_has_entity (out_if.has_entity),
    .out_last       (out_if.last),
    .out_overflow   (out_if.overflow),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  assign in_if.ready = in_ready;

  `UGSH_ASSERT_NXT(a_one_request, in_if.valid && in_ready, !in_ready)
  `UGSH_ASSERT_IMP(a_sweep_blocks, cmd.sweep_step, !in_ready)
  `UGSH_ASSERT_IMP(a_hit_room, cmd.ent_take && st.pend, st.out_free)
endmodule

/* test/grid_checker.sv */
module grid_checker
  import ugsh_pkg::*;
#(
  parameter int MAX_COLS      = 64,
  parameter int MAX_ROWS      = 64,
  parameter int CELL_CAPACITY = 16,
  parameter int MAX_RESULTS   = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  ugsh_in_if                in_mon,
  ugsh_out_if               out_mon,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [EID_W-1:0] id;
    logic             hit;
    logic             last;
    logic             ovf;
  } grid_result_t;

  grid_result_t    pending_hits[$];
  logic [CS_W-1:0]  cell_side;
  logic [DIM_W-1:0] cols_cfg;
  logic [DIM_W-1:0] rows_cfg;
  logic [4:0]       occupancy[MAX_COLS*MAX_ROWS];
  logic [EID_W-1:0] slots[MAX_COLS*MAX_ROWS*CELL_CAPACITY];

  assign outstanding = pending_hits.size();

  function automatic int clamp_dim(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic bit cell_span(int pos, int len, int cs, int n, output int lo, output int hi);
    lo = pos / cs;
    hi = (pos + len) / cs;
    if (lo < 0) lo = 0;
    if (hi > n - 1) hi = n - 1;
    return lo <= hi;
  endfunction

  // append one expected result at the tail
  function automatic void queue_result(grid_result_t v);
    pending_hits = {pending_hits, v};
  endfunction

  task automatic predict_request(logic [MODE_W-1:0] mode, logic [EID_W-1:0] id,
                                 int rx, int ry, int rw, int rh);
    int cs, cols, rows, x0, x1, y0, y1, c, k;
    bit any, ovf, trunc;
    grid_result_t r;
    cs   = (cell_side == 0) ? 1 : int'(cell_side);
    cols = clamp_dim(cols_cfg, MAX_COLS);
    rows = clamp_dim(rows_cfg, MAX_ROWS);
    any  = cell_span(rx, rw, cs, cols, x0, x1);
    any  = cell_span(ry, rh, cs, rows, y0, y1) && any;
    r = '{id: '0, hit: 1'b0, last: 1'b1, ovf: 1'b0};
    if (mode == MODE_CLEAR) begin
      foreach (occupancy[i]) occupancy[i] = '0;
      queue_result(r);
    end else if (mode == MODE_INSERT) begin
      ovf = 0;
      if (any) begin
        for (int y = y0; y <= y1; y++) begin
          for (int x = x0; x <= x1; x++) begin
            c = x + y * cols;
            if (occupancy[c] >= CELL_CAPACITY) begin
              ovf = 1;
            end else begin
              slots[c*CELL_CAPACITY + occupancy[c]] = id;
              occupancy[c] = occupancy[c] + 1;
            end
          end
        end
      end
      r.ovf = ovf;
      queue_result(r);
    end else if (mode == MODE_QUERY) begin
      k = 0;
      trunc = 0;
      if (any) begin
        for (int y = y0; y <= y1 && !trunc; y++) begin
          for (int x = x0; x <= x1 && !trunc; x++) begin
            c = x + y * cols;
            for (int s = 0; s < occupancy[c] && !trunc; s++) begin
              if (k >= MAX_RESULTS) begin
                trunc = 1;
              end else begin
                queue_result('{id: slots[c*CELL_CAPACITY + s], hit: 1'b1,
                               last: 1'b0, ovf: 1'b0});
                k++;
              end
            end
          end
        end
      end
      if (k == 0) begin
        queue_result(r);
      end else begin
        pending_hits[$].last = 1'b1;
        pending_hits[$].ovf  = trunc;
      end
    end else begin
      queue_result(r);
    end
  endtask

  always @(posedge clk) begin
    grid_result_t want;
    grid_result_t got;
    if (!rst_n) begin
      cell_side  <= CELL_SIZE_RST;
      cols_cfg   <= GRID_DIM_RST;
      rows_cfg   <= GRID_DIM_RST;
      mismatches <= 0;
      foreach (occupancy[i]) occupancy[i] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELL_SIZE: cell_side <= cfg_wdata;
          CFG_GRID_COLS: cols_cfg  <= cfg_wdata[DIM_W-1:0];
          CFG_GRID_ROWS: rows_cfg  <= cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_request(in_mon.mode, in_mon.entity_id, in_mon.rect_x, in_mon.rect_y,
                        in_mon.rect_w, in_mon.rect_h);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{id: out_mon.found_id, hit: out_mon.has_entity, last: out_mon.last,
                ovf: out_mon.overflow};
        if (pending_hits.size() == 0) begin
          if (mismatches < 10) $display("unexpected result id=%h hit=%b last=%b ovf=%b",
                                        got.id, got.hit, got.last, got.ovf);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_hits.pop_front();
          if (want !== got) begin
            if (mismatches < 10)
              $display("mismatch: expected id=%h hit=%b last=%b ovf=%b, got id=%h hit=%b last=%b ovf=%b",
                       want.id, want.hit, want.last, want.ovf,
                       got.id, got.hit, got.last, got.ovf);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

/* test/testbench.sv */
module testbench;
  import ugsh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  int                mismatches;
  int                outstanding;
  bit                calm;
  bit                hold_req;
  int                cur_cs, cur_cols, cur_rows;

  ugsh_in_if  in_bus ();
  ugsh_out_if out_bus ();

  uniform_grid_spatial_hash_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_bus),
    .out_if   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  grid_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    int n;
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 0;
        out_bus.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [MODE_W-1:0] mode, logic [EID_W-1:0] id,
                              logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                              logic [LEN_W-1:0] w, logic [LEN_W-1:0] h);
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= mode;
    in_bus.entity_id <= id;
    in_bus.rect_x    <= x;
    in_bus.rect_y    <= y;
    in_bus.rect_w    <= w;
    in_bus.rect_h    <= h;
    do @(posedge clk); while (!in_bus.ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_grid(int cs, int cols, int rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CELL_SIZE;
    cfg_wdata <= CFG_W'(cs);
    @(posedge clk);
    cfg_index <= CFG_GRID_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_cs   = (cs == 0) ? 1 : cs;
    cur_cols = (cols == 0) ? 1 : (cols > 64 ? 64 : cols);
    cur_rows = (rows == 0) ? 1 : (rows > 64 ? 64 : rows);
  endtask

  function automatic logic signed [POS_W-1:0] near_edge(int span, int cs);
    int v;
    v = $urandom_range(0, span + 2*cs) - cs;
    if (v > 16383) v = 16383;
    return POS_W'(v);
  endfunction

  task automatic random_requests(int count);
    logic [MODE_W-1:0] mode;
    int r, w_max;
    logic signed [POS_W-1:0] x, y;
    logic [LEN_W-1:0] w, h;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      mode = (r < 50) ? MODE_INSERT : (r < 88) ? MODE_QUERY : (r < 92) ? MODE_CLEAR
                                                                     : MODE_UNUSED;
      if ($urandom_range(0, 19) == 0) begin
        // noise: full-range rectangle
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        w = LEN_W'($urandom);
        h = LEN_W'($urandom);
      end else begin
        w_max = 2 * cur_cs;
        if (w_max > 16383) w_max = 16383;
        x = near_edge(cur_cs * cur_cols, cur_cs);
        y = near_edge(cur_cs * cur_rows, cur_cs);
        w = LEN_W'($urandom_range(0, w_max));
        h = LEN_W'($urandom_range(0, w_max));
      end
      send_request(mode, EID_W'($urandom), x, y, w, h);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    calm            = 0;
    hold_req        = 0;
    cur_cs          = 32;
    cur_cols        = 64;
    cur_rows        = 64;
    in_bus.valid     <= 1'b0;
    in_bus.mode      <= MODE_INSERT;
    in_bus.entity_id <= '0;
    in_bus.rect_x    <= '0;
    in_bus.rect_y    <= '0;
    in_bus.rect_w    <= '0;
    in_bus.rect_h    <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_CELL_SIZE;
    cfg_wdata       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill six cells past capacity, then read them back truncated
    for (int i = 0; i < 17; i++) send_request(MODE_INSERT, EID_W'(16'h1000 + i), 0, 0, 64, 32);
    send_request(MODE_QUERY, 0, 0, 0, 64, 32);
    send_request(MODE_QUERY, 0, -16384, 0, 0, 0);
    send_request(MODE_INSERT, 16'hFFFF, 16383, 16383, 16383, 16383);
    send_request(MODE_INSERT, 16'h0001, -31, -31, 0, 0);
    send_request(MODE_QUERY, 0, -16384, -16384, 16383, 16383);
    send_request(MODE_UNUSED, 16'hFFFF, -1, -1, 16383, 16383);
    send_request(MODE_CLEAR, 0, 0, 0, 0, 0);
    send_request(MODE_QUERY, 0, 0, 0, 16383, 16383);
    send_request(MODE_INSERT, 16'hFFFF, 0, 0, 16383, 16383);
    drain();

    // hold the result side while requests keep coming
    hold_req = 1;
    random_requests(70);
    drain();
    set_grid(1, 64, 64);
    random_requests(70);
    drain();
    set_grid(4096, 1, 1);
    random_requests(70);
    drain();
    set_grid(0, 0, 127);
    random_requests(70);
    drain();
    set_grid(13, 10, 5);
    random_requests(70);
    drain();
    set_grid(100, 64, 3);
    random_requests(35);
    calm = 1;
    random_requests(35);
    drain();
    repeat (200) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ugsh_pkg.sv
hw/rtl/ugsh_if.sv
hw/rtl/ugsh_ram.sv
hw/rtl/ugsh_div.sv
hw/rtl/ugsh_datapath.sv
hw/rtl/ugsh_ctrl.sv
hw/rtl/uniform_grid_spatial_hash_top.sv
test/grid_checker.sv
test/testbench.sv
